// ===== hdl/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket deframer with pong reply.
// No dependencies; used by every module under hdl/.
`default_nettype none

package wsdf_pkg;

  // Receive parser phase
  typedef enum logic [1:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_PAYLOAD
  } phase_e;

  // Command classes handed from the parser to the emitter
  typedef enum logic {
    CMD_SINGLE,
    CMD_PONG
  } cmd_e;

  // Length encoding chosen for the pong header
  typedef enum logic [1:0] {
    LEN_7,
    LEN_16,
    LEN_64
  } len_sel_e;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_PONG  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [7:0] PONG_HDR0   = MASK_BIT | {4'h0, OP_PONG};
  localparam logic [63:0] LEN16_MAX  = 64'h0000_0000_0000_ffff;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  // Index of the first mask byte and the final byte of a pong burst
  localparam logic [3:0] MBASE_7  = 4'd2;
  localparam logic [3:0] MBASE_16 = 4'd4;
  localparam logic [3:0] MBASE_64 = 4'd10;
  localparam logic [3:0] PLAST_7  = 4'd5;
  localparam logic [3:0] PLAST_16 = 4'd7;
  localparam logic [3:0] PLAST_64 = 4'd13;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        frame_end;
    len_sel_e    len_sel;
    logic [63:0] len;
    logic [31:0] mask;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/wsdf_front.sv =====
// Receive parser: accepts stream bytes, tracks header and payload, issues commands.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [31:0]       mask_word_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output wsdf_pkg::cmd_t         q_cmd_o
);

  wsdf_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [63:0] len_q, len_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] pmask_q, pmask_d;
  logic [1:0]  mpos_q, mpos_d;
  logic        closed_q, closed_d;

  logic        accept;
  logic        active;
  logic [6:0]  l7;
  logic [63:0] ext_len;
  logic [3:0]  hcount_dec;
  logic [63:0] remain_dec;
  logic        fin;
  logic        hdr_done;
  logic [63:0] hdr_len;
  logic        hdr_zero;
  logic [7:0]  mask_byte;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign active     = accept & ~action_i & ~closed_q;

  assign l7         = rx_byte_i[6:0];
  assign ext_len    = {len_q[55:0], rx_byte_i};
  assign hcount_dec = (hcount_q != 4'd0) ? hcount_q - 4'd1 : 4'd0;
  assign remain_dec = (remain_q != 64'd0) ? remain_q - 64'd1 : 64'd0;
  assign fin        = (remain_dec == 64'd0);
  assign mask_byte  = pmask_q[{mpos_q, 3'b000} +: 8];

  // Header completes on a short length byte or the final extended length byte
  always_comb begin
    hdr_done = 1'b0;
    hdr_len  = ext_len;
    unique case (phase_q)
      wsdf_pkg::PH_HDR1: begin
        hdr_len  = {57'd0, l7};
        hdr_done = (l7 != wsdf_pkg::LEN_CODE_16) && (l7 != wsdf_pkg::LEN_CODE_64);
      end
      wsdf_pkg::PH_EXT: begin
        hdr_done = (hcount_dec == 4'd0);
      end
      default: begin
        hdr_done = 1'b0;
      end
    endcase
    hdr_done = hdr_done & active;
  end

  assign hdr_zero = (hdr_len == 64'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept && action_i) begin
      phase_d = wsdf_pkg::PH_HDR0;
    end else if (active) begin
      unique case (phase_q)
        wsdf_pkg::PH_HDR0: phase_d = wsdf_pkg::PH_HDR1;
        wsdf_pkg::PH_HDR1: begin
          if (hdr_done) begin
            phase_d = hdr_zero ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_PAYLOAD;
          end else begin
            phase_d = wsdf_pkg::PH_EXT;
          end
        end
        wsdf_pkg::PH_EXT: begin
          if (hdr_done) begin
            phase_d = hdr_zero ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_PAYLOAD;
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          if (fin) begin
            phase_d = wsdf_pkg::PH_HDR0;
          end
        end
        default: phase_d = wsdf_pkg::PH_HDR0;
      endcase
    end
  end

  // Datapath and command output
  always_comb begin
    hcount_d = hcount_q;
    opcode_d = opcode_q;
    len_d    = len_q;
    remain_d = remain_q;
    pmask_d  = pmask_q;
    mpos_d   = mpos_q;
    closed_d = closed_q;
    q_push_o = 1'b0;
    q_cmd_o  = '{cmd: wsdf_pkg::CMD_SINGLE, kind: wsdf_pkg::KIND_TEXT, data: 8'd0,
                 frame_end: 1'b0, len_sel: wsdf_pkg::LEN_7, len: hdr_len,
                 mask: mask_word_i};

    if (accept && action_i) begin
      hcount_d = 4'd0;
      opcode_d = 4'd0;
      len_d    = 64'd0;
      remain_d = 64'd0;
      pmask_d  = 32'd0;
      mpos_d   = 2'd0;
      closed_d = 1'b0;
    end else if (active) begin
      unique case (phase_q)
        wsdf_pkg::PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
        end
        wsdf_pkg::PH_HDR1: begin
          len_d = hdr_done ? hdr_len : 64'd0;
          if (l7 == wsdf_pkg::LEN_CODE_16) begin
            hcount_d = wsdf_pkg::EXT_BYTES_16;
          end else if (l7 == wsdf_pkg::LEN_CODE_64) begin
            hcount_d = wsdf_pkg::EXT_BYTES_64;
          end
        end
        wsdf_pkg::PH_EXT: begin
          len_d    = ext_len;
          hcount_d = hcount_dec;
        end
        wsdf_pkg::PH_PAYLOAD: begin
          remain_d = remain_dec;
          if (opcode_q == wsdf_pkg::OP_TEXT) begin
            q_push_o          = 1'b1;
            q_cmd_o.kind      = wsdf_pkg::KIND_TEXT;
            q_cmd_o.data      = rx_byte_i;
            q_cmd_o.frame_end = fin;
          end else if (opcode_q == wsdf_pkg::OP_PING) begin
            q_push_o          = 1'b1;
            q_cmd_o.kind      = wsdf_pkg::KIND_PONG;
            q_cmd_o.data      = rx_byte_i ^ mask_byte;
            q_cmd_o.frame_end = fin;
            mpos_d            = mpos_q + 2'd1;
          end else if (opcode_q == wsdf_pkg::OP_CLOSE && fin) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = wsdf_pkg::KIND_CLOSE;
            closed_d     = 1'b1;
          end
        end
        default: begin
          remain_d = remain_q;
        end
      endcase

      if (hdr_done) begin
        if (!hdr_zero) begin
          remain_d = hdr_len;
        end
        if (opcode_q == wsdf_pkg::OP_PING) begin
          q_push_o    = 1'b1;
          q_cmd_o.cmd = wsdf_pkg::CMD_PONG;
          q_cmd_o.kind = wsdf_pkg::KIND_PONG;
          if (hdr_len < {57'd0, wsdf_pkg::LEN_CODE_16}) begin
            q_cmd_o.len_sel = wsdf_pkg::LEN_7;
          end else if (hdr_len <= wsdf_pkg::LEN16_MAX) begin
            q_cmd_o.len_sel = wsdf_pkg::LEN_16;
          end else begin
            q_cmd_o.len_sel = wsdf_pkg::LEN_64;
          end
          pmask_d = mask_word_i;
          mpos_d  = 2'd0;
        end else if (hdr_zero && opcode_q == wsdf_pkg::OP_TEXT) begin
          q_push_o          = 1'b1;
          q_cmd_o.kind      = wsdf_pkg::KIND_EMPTY;
          q_cmd_o.frame_end = 1'b1;
        end else if (hdr_zero && opcode_q == wsdf_pkg::OP_CLOSE) begin
          q_push_o     = 1'b1;
          q_cmd_o.kind = wsdf_pkg::KIND_CLOSE;
          closed_d     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsdf_pkg::PH_HDR0;
      hcount_q <= 4'd0;
      opcode_q <= 4'd0;
      len_q    <= 64'd0;
      remain_q <= 64'd0;
      pmask_q  <= 32'd0;
      mpos_q   <= 2'd0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hcount_q <= hcount_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      remain_q <= remain_d;
      pmask_q  <= pmask_d;
      mpos_q   <= mpos_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wsdf_fifo.sv =====
// Short command queue between the parser and the emitter.
// Depends on wsdf_pkg for the command word type.
`default_nettype none

module wsdf_fifo #(
  parameter int unsigned Depth = wsdf_pkg::FIFO_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wsdf_pkg::cmd_t  push_cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output wsdf_pkg::cmd_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  wsdf_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wsdf_back.sv =====
// Result emitter: expands queued commands into result words, pong headers byte by byte.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire wsdf_pkg::cmd_t  q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           data_o,
  output logic                 frame_end_o,
  output logic                 last_o
);

  logic [3:0] step_q, step_d;
  logic       valid_q;
  logic [1:0] kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic       fe_q, fe_d;
  logic       last_q, last_d;

  logic       load;
  logic [3:0] pong_last;
  logic [3:0] mbase;
  logic [3:0] mask_off;
  logic [3:0] len_off;
  logic [7:0] len_byte;
  logic       len_zero;

  assign load = ~valid_q | out_ready_i;

  always_comb begin
    unique case (q_head_i.len_sel)
      wsdf_pkg::LEN_16: begin
        pong_last = wsdf_pkg::PLAST_16;
        mbase     = wsdf_pkg::MBASE_16;
      end
      wsdf_pkg::LEN_64: begin
        pong_last = wsdf_pkg::PLAST_64;
        mbase     = wsdf_pkg::MBASE_64;
      end
      default: begin
        pong_last = wsdf_pkg::PLAST_7;
        mbase     = wsdf_pkg::MBASE_7;
      end
    endcase
  end

  assign mask_off = step_q - mbase;
  // Extended length goes out most significant byte first
  assign len_off  = mbase - 4'd1 - step_q;
  assign len_zero = (q_head_i.len[6:0] == 7'd0);

  always_comb begin
    len_byte = q_head_i.len[{len_off[2:0], 3'b000} +: 8];
    if (step_q == 4'd1) begin
      unique case (q_head_i.len_sel)
        wsdf_pkg::LEN_16: len_byte = wsdf_pkg::MASK_BIT | {1'b0, wsdf_pkg::LEN_CODE_16};
        wsdf_pkg::LEN_64: len_byte = wsdf_pkg::MASK_BIT | {1'b0, wsdf_pkg::LEN_CODE_64};
        default:          len_byte = wsdf_pkg::MASK_BIT | {1'b0, q_head_i.len[6:0]};
      endcase
    end
  end

  always_comb begin
    step_d  = step_q;
    kind_d  = kind_q;
    data_d  = data_q;
    fe_d    = fe_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load && q_valid_i) begin
      kind_d = q_head_i.kind;
      unique case (q_head_i.cmd)
        wsdf_pkg::CMD_PONG: begin
          if (step_q == 4'd0) begin
            data_d = wsdf_pkg::PONG_HDR0;
          end else if (step_q < mbase) begin
            data_d = len_byte;
          end else begin
            data_d = q_head_i.mask[{mask_off[1:0], 3'b000} +: 8];
          end
          if (step_q == pong_last) begin
            fe_d    = (q_head_i.len_sel == wsdf_pkg::LEN_7) && len_zero;
            last_d  = 1'b1;
            q_pop_o = 1'b1;
            step_d  = 4'd0;
          end else begin
            fe_d   = 1'b0;
            last_d = 1'b0;
            step_d = step_q + 4'd1;
          end
        end
        default: begin
          data_d  = q_head_i.data;
          fe_d    = q_head_i.frame_end;
          last_d  = 1'b1;
          q_pop_o = 1'b1;
          step_d  = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 4'd0;
    end else begin
      if (load) begin
        valid_q <= q_valid_i;
      end
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    fe_q   <= fe_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign frame_end_o = fe_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hdl/websocket_deframer_with_pong_core.sv =====
// Top level of the WebSocket receive deframer with pong reply.
// Depends on wsdf_pkg, wsdf_front, wsdf_fifo and wsdf_back.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o    | action_i, rx_byte_i, mask_word_i
//   out     | out_valid_o / out_ready_i  | kind_o, data_o, frame_end_o, last_o
//
// One input byte is taken per cycle while the command queue has room; the
// parser decides each byte in the cycle it is accepted.
// A pong header is 6, 8 or 14 result words (short, 16-bit, 64-bit length), so
// the emitter sets the rate during pongs and the queue (FIFO_DEPTH commands)
// absorbs the burst before in_ready_o drops.
// Results pass through the queue entry and then the emitter's output register;
// out_ready_i low holds the output register and in turn fills the queue.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none

module websocket_deframer_with_pong_core #(
  parameter int unsigned FifoDepth = wsdf_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] mask_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_o,
  output logic             frame_end_o,
  output logic             last_o
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  wsdf_pkg::cmd_t q_cmd;
  wsdf_pkg::cmd_t q_head;

  wsdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .rx_byte_i   (rx_byte_i),
    .mask_word_i (mask_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  wsdf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  wsdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .frame_end_o (frame_end_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for websocket_deframer_with_pong_core.
// Needs wsdf_pkg and the RTL under hdl/; drives random byte streams with gaps and
// stalls, predicts every result word and checks it in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords = 450;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 50;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } ws_result_t;

  typedef struct packed {
    logic        act;
    logic [7:0]  b;
    logic [31:0] mask;
  } rx_word_t;

  // Parser shadow plus the queue of result words still owed by the block
  class deframe_tracker;
    wsdf_pkg::phase_e phase;
    logic [3:0]  ext_left;
    logic [3:0]  opcode;
    logic [63:0] len_acc;
    logic [63:0] remaining;
    logic [31:0] pong_mask;
    logic [1:0]  mask_pos;
    logic        closed;
    ws_result_t  owed[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned pong_bytes;
    int unsigned closes;

    function new();
      clear_parser();
    endfunction

    function void clear_parser();
      phase     = wsdf_pkg::PH_HDR0;
      ext_left  = '0;
      opcode    = '0;
      len_acc   = '0;
      remaining = '0;
      pong_mask = '0;
      mask_pos  = '0;
      closed    = 1'b0;
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] data, logic fe);
      ws_result_t r;
      r.kind      = kind;
      r.data      = data;
      r.frame_end = fe;
      r.last      = 1'b0;
      owed.push_back(r);
    endfunction

    function void header_complete(logic [31:0] m);
      if (opcode == wsdf_pkg::OP_PING) begin
        owe(wsdf_pkg::KIND_PONG, wsdf_pkg::PONG_HDR0, 1'b0);
        if (len_acc < {57'd0, wsdf_pkg::LEN_CODE_16}) begin
          owe(wsdf_pkg::KIND_PONG, wsdf_pkg::MASK_BIT | len_acc[7:0], 1'b0);
        end else if (len_acc <= wsdf_pkg::LEN16_MAX) begin
          owe(wsdf_pkg::KIND_PONG, wsdf_pkg::MASK_BIT | {1'b0, wsdf_pkg::LEN_CODE_16}, 1'b0);
          owe(wsdf_pkg::KIND_PONG, len_acc[15:8], 1'b0);
          owe(wsdf_pkg::KIND_PONG, len_acc[7:0], 1'b0);
        end else begin
          owe(wsdf_pkg::KIND_PONG, wsdf_pkg::MASK_BIT | {1'b0, wsdf_pkg::LEN_CODE_64}, 1'b0);
          for (int i = 7; i >= 0; i--) owe(wsdf_pkg::KIND_PONG, len_acc[8*i +: 8], 1'b0);
        end
        pong_mask = m;
        mask_pos  = '0;
        for (int i = 0; i < 4; i++) begin
          owe(wsdf_pkg::KIND_PONG, m[8*i +: 8], len_acc == 64'd0 && i == 3);
        end
      end
      if (len_acc == 64'd0) begin
        if (opcode == wsdf_pkg::OP_TEXT) begin
          owe(wsdf_pkg::KIND_EMPTY, 8'h00, 1'b1);
        end else if (opcode == wsdf_pkg::OP_CLOSE) begin
          owe(wsdf_pkg::KIND_CLOSE, 8'h00, 1'b0);
          closed = 1'b1;
        end
        phase = wsdf_pkg::PH_HDR0;
      end else begin
        remaining = len_acc;
        phase     = wsdf_pkg::PH_PAYLOAD;
      end
    endfunction

    // Called for every accepted input word
    function void note_word(logic act, logic [7:0] b, logic [31:0] m);
      int unsigned n0;
      logic        fin;
      logic [7:0]  mb;
      n0 = owed.size();
      if (act) begin
        clear_parser();
        return;
      end
      if (closed) return;
      case (phase)
        wsdf_pkg::PH_HDR0: begin
          opcode = b[3:0];
          phase  = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          len_acc = '0;
          if (b[6:0] == wsdf_pkg::LEN_CODE_16) begin
            ext_left = wsdf_pkg::EXT_BYTES_16;
            phase    = wsdf_pkg::PH_EXT;
          end else if (b[6:0] == wsdf_pkg::LEN_CODE_64) begin
            ext_left = wsdf_pkg::EXT_BYTES_64;
            phase    = wsdf_pkg::PH_EXT;
          end else begin
            len_acc = {57'd0, b[6:0]};
            header_complete(m);
          end
        end
        wsdf_pkg::PH_EXT: begin
          len_acc = {len_acc[55:0], b};
          if (ext_left != 4'd0) ext_left--;
          if (ext_left == 4'd0) header_complete(m);
        end
        default: begin
          if (remaining != 64'd0) remaining--;
          fin = (remaining == 64'd0);
          if (opcode == wsdf_pkg::OP_TEXT) begin
            owe(wsdf_pkg::KIND_TEXT, b, fin);
          end else if (opcode == wsdf_pkg::OP_PING) begin
            mb = pong_mask[{mask_pos, 3'b000} +: 8];
            owe(wsdf_pkg::KIND_PONG, b ^ mb, fin);
            mask_pos++;
          end else if (opcode == wsdf_pkg::OP_CLOSE && fin) begin
            owe(wsdf_pkg::KIND_CLOSE, 8'h00, 1'b0);
            closed = 1'b1;
          end
          if (fin) phase = wsdf_pkg::PH_HDR0;
        end
      endcase
      if (owed.size() > n0) owed[owed.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_word(ws_result_t got);
      ws_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t ns: unexpected result word, kind %0d data %02h", $time, got.kind,
                   got.data);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (want.kind == wsdf_pkg::KIND_PONG) pong_bytes++;
      if (want.kind == wsdf_pkg::KIND_CLOSE) closes++;
      compare_field("kind", {6'd0, want.kind}, {6'd0, got.kind});
      compare_field("data", want.data, got.data);
      compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
      compare_field("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic [31:0] mask_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        frame_end;
  logic        last;

  int unsigned idle_cycles = 0;
  int unsigned words_in = 0;
  logic        stuck;
  rx_word_t    stim_q[$];
  deframe_tracker tracker = new();

  assign stuck = idle_cycles >= StallLimit;

  websocket_deframer_with_pong_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .rx_byte_i   (rx_byte),
    .mask_word_i (mask_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .data_o      (data),
    .frame_end_o (frame_end),
    .last_o      (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic put(input logic act, input logic [7:0] b);
    rx_word_t w;
    w.act  = act;
    w.b    = b;
    w.mask = $urandom;
    stim_q.push_back(w);
  endtask

  // Header, extended length and payload; a short payload is cut by a connection start
  task automatic put_frame(input logic [3:0] op, input logic [63:0] len,
                           input wsdf_pkg::len_sel_e enc, input int unsigned npay);
    logic [3:0] hi;
    logic       mbit;
    hi   = 4'($urandom);
    mbit = 1'($urandom);
    put(1'b0, {hi, op});
    case (enc)
      wsdf_pkg::LEN_7: put(1'b0, {mbit, len[6:0]});
      wsdf_pkg::LEN_16: begin
        put(1'b0, {mbit, wsdf_pkg::LEN_CODE_16});
        put(1'b0, len[15:8]);
        put(1'b0, len[7:0]);
      end
      default: begin
        put(1'b0, {mbit, wsdf_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) put(1'b0, len[8*i +: 8]);
      end
    endcase
    repeat (npay) put(1'b0, 8'($urandom));
    if (64'(npay) < len) begin
      put(1'b1, 8'($urandom));
    end else if (op == wsdf_pkg::OP_CLOSE) begin
      repeat ($urandom_range(0, 3)) put(1'b0, 8'($urandom));
      put(1'b1, 8'($urandom));
    end
  endtask

  task automatic send_word(input rx_word_t w);
    in_valid  <= 1'b1;
    action    <= w.act;
    rx_byte   <= w.b;
    mask_word <= w.mask;
    do @(posedge clk); while (!in_ready && !stuck);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_word({kind, data, frame_end, last});
      if (in_valid && in_ready) begin
        tracker.note_word(action, rx_byte, mask_word);
        words_in++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver side: ready runs, some long, broken by stalls
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      out_ready <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  end

  initial begin
    int unsigned n_directed;
    int unsigned r;
    int unsigned gap;
    int unsigned burst_left;
    int unsigned npay;
    logic [3:0]  op;
    logic [63:0] len;
    wsdf_pkg::len_sel_e enc;
    rx_word_t    w;

    // Directed opening
    put(1'b1, 8'h00);
    put(1'b0, 8'h81);
    put(1'b0, 8'h80);                         // empty text frame, mask bit set
    put(1'b0, 8'h01);
    put(1'b0, 8'h02);
    put(1'b0, 8'h00);
    put(1'b0, 8'hff);                         // text with FIN clear, byte extremes
    put(1'b0, 8'h89);
    stim_q.push_back({1'b0, 8'h00, 32'hffff_ffff});  // empty ping, all-ones mask
    put(1'b0, 8'h89);
    put(1'b0, 8'h7e);
    put(1'b0, 8'h00);
    stim_q.push_back({1'b0, 8'h01, 32'h0000_0000});  // 16-bit code, short pong reply
    put(1'b0, 8'ha5);
    put(1'b0, 8'h0a);
    put(1'b0, 8'h01);
    put(1'b0, 8'h3c);                         // received pong is dropped
    put(1'b0, 8'h88);
    put(1'b0, 8'h00);                         // empty close
    put(1'b0, 8'h81);                         // ignored while closed
    put(1'b1, 8'hff);
    put_frame(wsdf_pkg::OP_PING, 64'h8000_0000_0000_0001, wsdf_pkg::LEN_64, 1);
    n_directed = stim_q.size();

    while (stim_q.size() < n_directed + RandomWords) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) put($urandom_range(0, 3) == 0, 8'($urandom));
        if ($urandom_range(0, 1)) put(1'b1, 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) op = wsdf_pkg::OP_TEXT;
        else if (r < 65) op = wsdf_pkg::OP_PING;
        else if (r < 73) op = wsdf_pkg::OP_CLOSE;
        else do op = 4'($urandom); while (op == wsdf_pkg::OP_TEXT ||
                                          op == wsdf_pkg::OP_CLOSE ||
                                          op == wsdf_pkg::OP_PING);
        r = $urandom_range(0, 99);
        if (r < 60) begin
          enc = wsdf_pkg::LEN_7;
          len = 64'($urandom_range(0, 12));
        end else if (r < 63) begin
          enc = wsdf_pkg::LEN_7;
          len = 64'($urandom_range(113, 125));
        end else if (r < 78) begin
          enc = wsdf_pkg::LEN_16;
          len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 140))
                                            : 64'($urandom_range(0, 12));
        end else if (r < 85) begin
          enc = wsdf_pkg::LEN_16;
          len = 64'($urandom_range(141, 65535));
        end else if (r < 93) begin
          enc = wsdf_pkg::LEN_64;
          len = 64'($urandom_range(0, 20));
        end else begin
          enc = wsdf_pkg::LEN_64;
          len = {$urandom, $urandom};
        end
        npay = (len <= 64'd140) ? len[31:0] : $urandom_range(0, 6);
        if (npay > 0 && $urandom_range(0, 19) == 0) npay = $urandom_range(0, npay - 1);
        put_frame(op, len, enc, npay);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    while (stim_q.size() > 0 && !stuck) begin
      w = stim_q.pop_front();
      send_word(w);
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        burst_left = 40;
        gap = 0;
      end else begin
        gap = ($urandom_range(0, 99) < 55) ? 0 : pick_gap();
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed.size() != 0 && !stuck) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (stuck) $display("%0t ns: no word moved for %0d cycles", $time, StallLimit);
    if (tracker.owed.size() != 0) begin
      tracker.errors++;
      $display("%0t ns: %0d result words never arrived, next expected kind %0d data %02h",
               $time, tracker.owed.size(), tracker.owed[0].kind, tracker.owed[0].data);
    end
    $display("Run covered %0d input words and %0d checked result words (%0d pong bytes,",
             words_in, tracker.checked, tracker.pong_bytes);
    $display("  %0d close reports), with %0d mismatches.", tracker.closes, tracker.errors);
    if (!stuck && tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wsdf_pkg.sv
hdl/wsdf_front.sv
hdl/wsdf_fifo.sv
hdl/wsdf_back.sv
hdl/websocket_deframer_with_pong_core.sv
tb/sv/testbench.sv
